[src/ipt_pkg.sv]
// ----------------------------------------------------------------------------
// ipt_pkg
// types, operation codes and state encoding shared by the packet table
// ----------------------------------------------------------------------------
package ipt_pkg;

    localparam int unsigned DEPTH = 16;
    localparam int unsigned KIND_W = 4;
    localparam int unsigned CLASS_W = 4;
    localparam int unsigned ID_W = 16;
    localparam int unsigned TAG_W = 32;
    localparam int unsigned POS_W = 4;
    localparam int unsigned CNT_W = 5;

    typedef enum logic [KIND_W-1:0] {
        K_APPEND = 4'd0,
        K_GET_AT = 4'd1,
        K_PEEK   = 4'd2,
        K_MARK   = 4'd3,
        K_DROP   = 4'd4,
        K_DELETE = 4'd5,
        K_SHIFT  = 4'd6,
        K_POP    = 4'd7,
        K_MISC   = 4'd8
    } t_kind;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CLASS_W-1:0] entry_class;
        logic [ID_W-1:0]    pkt_id;
        logic [TAG_W-1:0]   tag;
        logic [POS_W-1:0]   position;
        logic               take_id;
    } t_in_item;

    typedef struct packed {
        logic               ok;
        logic [CLASS_W-1:0] out_class;
        logic [ID_W-1:0]    out_pkt_id;
        logic [TAG_W-1:0]   out_tag;
        logic [CNT_W-1:0]   entry_count;
        logic               has_current;
        logic               queueable;
        logic [ID_W-1:0]    new_id;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_ctrl;

endpackage

[src/ipt_ctrl.sv]
// ----------------------------------------------------------------------------
// ipt_ctrl
// controller: captures a command then runs the execute cycle
// ----------------------------------------------------------------------------
module ipt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    output ipt_pkg::t_ctrl o_ctrl
);

    ipt_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl = '0;
        busy = 1'b0;
        unique case (r_state)
            ipt_pkg::S_IDLE: begin
                if (start) begin
                    o_ctrl.load = 1'b1;
                    n_state = ipt_pkg::S_EXEC;
                end
            end
            ipt_pkg::S_EXEC: begin
                busy = 1'b1;
                o_ctrl.exec = 1'b1;
                n_state = ipt_pkg::S_IDLE;
            end
            default: n_state = ipt_pkg::S_IDLE;
        endcase
    end

endmodule

[src/ipt_datapath.sv]
// ----------------------------------------------------------------------------
// ipt_datapath
// slot cells with parallel key compare and compacting shift, plus counters
// ----------------------------------------------------------------------------
module ipt_datapath #(
    parameter int unsigned TAG_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ipt_pkg::t_ctrl      i_ctrl,
    input  ipt_pkg::t_in_item   i_item,
    input  logic                i_cfg_we,
    input  logic [4:0]          i_cfg_data,
    output logic                o_strobe,
    output ipt_pkg::t_out_item  o_result
);

    localparam int unsigned DEPTH = ipt_pkg::DEPTH;
    localparam int unsigned TW = ipt_pkg::TAG_W;
    localparam int unsigned CW = ipt_pkg::CNT_W;
    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned FW = $clog2(DEPTH + 1);

    logic [ipt_pkg::CLASS_W-1:0] r_cls [DEPTH];
    logic [ipt_pkg::ID_W-1:0]    r_pid [DEPTH];
    logic [TAG_BITS-1:0]         r_tag [DEPTH];
    logic [FW-1:0]               r_fill, n_fill;
    logic [FW-1:0]               r_cur, n_cur;
    logic [ipt_pkg::ID_W-1:0]    r_idc, n_idc;
    logic [4:0]                  r_cap;
    ipt_pkg::t_in_item           r_item;
    logic                        r_strobe;
    ipt_pkg::t_out_item          r_res, n_res;

    logic [FW-1:0] eff_cap, pos_ext, rm_pos, rd_pos;
    logic          do_rm, do_app, hit;
    logic [DEPTH-1:0] match;
    logic [IW-1:0] first_idx;

    assign eff_cap = (r_cap > 5'(DEPTH)) ? FW'(DEPTH) : FW'(r_cap);
    assign pos_ext = FW'(r_item.position);

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            match[k] = (FW'(k) < r_cur) && (FW'(k) < r_fill)
                && (r_cls[k] == r_item.entry_class) && (r_pid[k] == r_item.pkt_id);
        end
        hit = |match;
        first_idx = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (match[k]) first_idx = IW'(k);
        end
    end

    always_comb begin
        n_fill = r_fill;
        n_cur = r_cur;
        n_idc = r_idc;
        n_res = '0;
        do_rm = 1'b0;
        do_app = 1'b0;
        rm_pos = '0;
        rd_pos = '0;
        case (r_item.kind)
            ipt_pkg::K_APPEND: begin
                do_app = (r_fill < eff_cap);
                n_res.ok = do_app;
            end
            ipt_pkg::K_GET_AT: rd_pos = pos_ext;
            ipt_pkg::K_PEEK: rd_pos = r_cur;
            ipt_pkg::K_MARK: n_res.ok = (r_cur < r_fill);
            ipt_pkg::K_DROP: rd_pos = r_cur;
            ipt_pkg::K_DELETE: rd_pos = pos_ext;
            ipt_pkg::K_SHIFT: rd_pos = '0;
            ipt_pkg::K_POP: rd_pos = FW'(first_idx);
            ipt_pkg::K_MISC: n_res.ok = 1'b1;
            default: ;
        endcase
        if (r_item.kind inside {ipt_pkg::K_GET_AT, ipt_pkg::K_PEEK, ipt_pkg::K_DROP,
                                ipt_pkg::K_DELETE, ipt_pkg::K_SHIFT}) begin
            n_res.ok = (rd_pos < r_fill);
        end
        if (r_item.kind == ipt_pkg::K_POP) n_res.ok = hit;
        if (n_res.ok && (r_item.kind inside {ipt_pkg::K_GET_AT, ipt_pkg::K_PEEK,
                ipt_pkg::K_DROP, ipt_pkg::K_DELETE, ipt_pkg::K_SHIFT, ipt_pkg::K_POP})) begin
            n_res.out_class = r_cls[rd_pos[IW-1:0]];
            n_res.out_pkt_id = r_pid[rd_pos[IW-1:0]];
            n_res.out_tag = TW'(r_tag[rd_pos[IW-1:0]]);
        end
        if (n_res.ok && (r_item.kind inside {ipt_pkg::K_DROP, ipt_pkg::K_DELETE,
                ipt_pkg::K_SHIFT, ipt_pkg::K_POP})) begin
            do_rm = 1'b1;
            rm_pos = rd_pos;
            n_fill = r_fill - FW'(1);
            if (r_cur > rd_pos) n_cur = r_cur - FW'(1);
        end
        if (do_app) n_fill = r_fill + FW'(1);
        if (r_item.kind == ipt_pkg::K_MARK && n_res.ok) n_cur = r_cur + FW'(1);
        if (r_item.kind == ipt_pkg::K_MISC) begin
            if (r_item.take_id) begin
                n_res.new_id = r_idc;
                n_idc = r_idc + 1'b1;
            end else begin
                n_cur = '0;
            end
        end
        n_res.entry_count = CW'(n_fill);
        n_res.has_current = (n_cur < n_fill);
        n_res.queueable = (n_fill < eff_cap);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) r_item <= i_item;
        if (i_ctrl.exec) begin
            r_res <= n_res;
            for (int k = 0; k < DEPTH - 1; k++) begin
                if (do_rm && FW'(k) >= rm_pos) begin
                    r_cls[k] <= r_cls[k + 1];
                    r_pid[k] <= r_pid[k + 1];
                    r_tag[k] <= r_tag[k + 1];
                end
            end
            for (int k = 0; k < DEPTH; k++) begin
                if (do_app && FW'(k) == r_fill) begin
                    r_cls[k] <= r_item.entry_class;
                    r_pid[k] <= r_item.pkt_id;
                    r_tag[k] <= TAG_BITS'(r_item.tag);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_cur <= '0;
            r_idc <= '0;
            r_cap <= 5'd16;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_ctrl.exec;
            if (i_cfg_we) r_cap <= i_cfg_data;
            if (i_ctrl.exec) begin
                r_fill <= n_fill;
                r_cur <= n_cur;
                r_idc <= n_idc;
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

[src/inflight_packet_table.sv]
// ----------------------------------------------------------------------------
// inflight_packet_table
// ordered in-flight packet table with send cursor and id counter
// ----------------------------------------------------------------------------
// command registered when accepted; result and strobe registered in the execute step
// busy is high in the execute step; a new command waits until capture and execute end
// reset: synchronous active low; count, cursor and id clear, capacity 16
// slot contents are not cleared; the receiver cannot stall results
module inflight_packet_table #(
    parameter int unsigned TAG_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ipt_pkg::t_in_item  i_item,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_data,
    output logic               o_strobe,
    output ipt_pkg::t_out_item o_result
);

    ipt_pkg::t_ctrl ctrl;

    ipt_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .o_ctrl (ctrl)
    );

    ipt_datapath #(.TAG_BITS(TAG_BITS)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .i_item    (i_item),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

endmodule

[test/ipt_checker.sv]
// ----------------------------------------------------------------------------
// ipt_checker
// watches command and result beats of the packet table, predicts each result
// from a local copy of the table state and compares field by field
// ----------------------------------------------------------------------------
module ipt_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  ipt_pkg::t_in_item  i_item,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_data,
    input  logic               i_strobe,
    input  ipt_pkg::t_out_item i_result,
    output int                 o_errors,
    output int                 o_pending
);

    localparam int DEPTH = ipt_pkg::DEPTH;

    logic [ipt_pkg::CLASS_W-1:0] tbl_class [DEPTH];
    logic [ipt_pkg::ID_W-1:0]    tbl_id [DEPTH];
    logic [ipt_pkg::TAG_W-1:0]   tbl_tag [DEPTH];
    int                          tbl_fill;
    int                          tbl_cursor;
    logic [ipt_pkg::ID_W-1:0]    id_next;
    logic [4:0]                  capacity;
    ipt_pkg::t_out_item          expected_q [$];

    function automatic int cap_limit();
        return (int'(capacity) > DEPTH) ? DEPTH : int'(capacity);
    endfunction

    function automatic bit take_slot(int p, ref ipt_pkg::t_out_item r);
        if (p >= tbl_fill) return 0;
        r.out_class = tbl_class[p];
        r.out_pkt_id = tbl_id[p];
        r.out_tag = tbl_tag[p];
        return 1;
    endfunction

    function automatic bit remove_slot(int p, ref ipt_pkg::t_out_item r);
        if (!take_slot(p, r)) return 0;
        for (int i = p; i + 1 < tbl_fill; i++) begin
            tbl_class[i] = tbl_class[i+1];
            tbl_id[i] = tbl_id[i+1];
            tbl_tag[i] = tbl_tag[i+1];
        end
        tbl_fill--;
        if (tbl_cursor > p) tbl_cursor--;
        return 1;
    endfunction

    function automatic ipt_pkg::t_out_item table_op(ipt_pkg::t_in_item c);
        ipt_pkg::t_out_item r;
        bit ok;
        r = '0;
        ok = 0;
        case (c.kind)
            ipt_pkg::K_APPEND: begin
                if (tbl_fill < cap_limit()) begin
                    tbl_class[tbl_fill] = c.entry_class;
                    tbl_id[tbl_fill] = c.pkt_id;
                    tbl_tag[tbl_fill] = c.tag;
                    tbl_fill++;
                    ok = 1;
                end
            end
            ipt_pkg::K_GET_AT: ok = take_slot(int'(c.position), r);
            ipt_pkg::K_PEEK:   ok = take_slot(tbl_cursor, r);
            ipt_pkg::K_MARK: begin
                if (tbl_cursor < tbl_fill) begin
                    tbl_cursor++;
                    ok = 1;
                end
            end
            ipt_pkg::K_DROP:   ok = remove_slot(tbl_cursor, r);
            ipt_pkg::K_DELETE: ok = remove_slot(int'(c.position), r);
            ipt_pkg::K_SHIFT:  ok = remove_slot(0, r);
            ipt_pkg::K_POP: begin
                for (int i = 0; i < tbl_cursor && i < tbl_fill; i++) begin
                    if (!ok && tbl_class[i] == c.entry_class && tbl_id[i] == c.pkt_id)
                        ok = remove_slot(i, r);
                end
            end
            ipt_pkg::K_MISC: begin
                if (c.take_id) begin
                    r.new_id = id_next;
                    id_next = id_next + 1'b1;
                end else begin
                    tbl_cursor = 0;
                end
                ok = 1;
            end
            default: ok = 0;
        endcase
        if (!ok) begin
            r.out_class = '0;
            r.out_pkt_id = '0;
            r.out_tag = '0;
        end
        r.ok = ok;
        r.entry_count = ipt_pkg::CNT_W'(tbl_fill);
        r.has_current = tbl_cursor < tbl_fill;
        r.queueable = tbl_fill < cap_limit();
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        ipt_pkg::t_out_item e;
        if (!i_rst_n) begin
            tbl_fill = 0;
            tbl_cursor = 0;
            id_next = '0;
            capacity = 5'd16;
            o_errors = 0;
            expected_q.delete();
        end else begin
            if (i_strobe) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", 64'(i_result), 64'(0));
                end else begin
                    e = expected_q.pop_front();
                    if (i_result.ok !== e.ok)
                        report_mismatch("ok", 64'(i_result.ok), 64'(e.ok));
                    if (i_result.out_class !== e.out_class)
                        report_mismatch("class", 64'(i_result.out_class), 64'(e.out_class));
                    if (i_result.out_pkt_id !== e.out_pkt_id)
                        report_mismatch("packet id", 64'(i_result.out_pkt_id),
                                        64'(e.out_pkt_id));
                    if (i_result.out_tag !== e.out_tag)
                        report_mismatch("tag", 64'(i_result.out_tag), 64'(e.out_tag));
                    if (i_result.entry_count !== e.entry_count)
                        report_mismatch("count", 64'(i_result.entry_count),
                                        64'(e.entry_count));
                    if (i_result.has_current !== e.has_current)
                        report_mismatch("has current", 64'(i_result.has_current),
                                        64'(e.has_current));
                    if (i_result.queueable !== e.queueable)
                        report_mismatch("queueable", 64'(i_result.queueable),
                                        64'(e.queueable));
                    if (i_result.new_id !== e.new_id)
                        report_mismatch("new id", 64'(i_result.new_id), 64'(e.new_id));
                end
            end
            if (i_cfg_we) capacity = i_cfg_data;
            if (i_start && !i_busy) expected_q.push_back(table_op(i_item));
        end
        o_pending = expected_q.size();
    end
endmodule

[test/tb_inflight_packet_table.sv]
// ----------------------------------------------------------------------------
// tb_inflight_packet_table
// drives directed and random table commands through several capacity
// settings; a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_inflight_packet_table;

    localparam logic [ipt_pkg::KIND_W-1:0] K_RESERVED = 4'd15;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    ipt_pkg::t_in_item  i_item;
    logic               i_cfg_we;
    logic [4:0]         i_cfg_data;
    logic               o_strobe;
    ipt_pkg::t_out_item o_result;
    int                 errors;
    int                 pending;
    int                 idle_cycles;
    bit                 no_gaps;

    inflight_packet_table u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe), .o_result(o_result)
    );

    ipt_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_item(i_item), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_strobe(o_strobe), .i_result(o_result),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_beat(ipt_pkg::t_in_item c);
        while (!no_gaps && $urandom_range(99) < 35) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_item <= c;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic send_op(logic [ipt_pkg::KIND_W-1:0] k, logic [3:0] cls,
                           logic [15:0] pid, logic [3:0] pos, logic take);
        ipt_pkg::t_in_item c;
        c.kind = k;
        c.entry_class = cls;
        c.pkt_id = pid;
        c.tag = {$urandom};
        c.position = pos;
        c.take_id = take;
        send_beat(c);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [4:0] v);
        drain();
        i_cfg_data <= v;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_op();
        ipt_pkg::t_in_item c;
        int r;
        c.tag = {$urandom};
        c.entry_class = 4'($urandom_range(3));
        c.pkt_id = 16'($urandom_range(7));
        c.position = 4'($urandom_range(15));
        c.take_id = 1'($urandom);
        r = $urandom_range(99);
        if (r < 30) c.kind = ipt_pkg::K_APPEND;
        else if (r < 40) c.kind = ipt_pkg::K_MARK;
        else if (r < 48) c.kind = ipt_pkg::K_POP;
        else if (r < 93) c.kind = 4'($urandom_range(8));
        else c.kind = 4'($urandom_range(15));
        if ($urandom_range(9) == 0) begin
            c.entry_class = 4'($urandom);
            c.pkt_id = 16'($urandom);
        end
        send_beat(c);
    endtask

    initial begin
        logic [4:0] caps [5];
        caps = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd5};
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        no_gaps = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table misses, fill, reads, removals, id take, cursor reset, reserved kind
        send_op(ipt_pkg::K_PEEK, 0, 0, 0, 0);
        send_op(ipt_pkg::K_MARK, 0, 0, 0, 0);
        send_op(ipt_pkg::K_DROP, 0, 0, 0, 0);
        send_op(ipt_pkg::K_SHIFT, 0, 0, 0, 0);
        send_op(ipt_pkg::K_GET_AT, 0, 0, 4'd15, 0);
        for (int i = 0; i < 17; i++)
            send_op(ipt_pkg::K_APPEND, 4'(i), (i == 0) ? 16'hffff : 16'(i), 0, 0);
        send_op(ipt_pkg::K_GET_AT, 0, 0, 4'd15, 0);
        send_op(ipt_pkg::K_MARK, 0, 0, 0, 0);
        send_op(ipt_pkg::K_MARK, 0, 0, 0, 0);
        send_op(ipt_pkg::K_POP, 4'd1, 16'd1, 0, 0);
        send_op(ipt_pkg::K_POP, 4'd15, 16'd15, 0, 0);
        send_op(ipt_pkg::K_PEEK, 0, 0, 0, 0);
        send_op(ipt_pkg::K_DROP, 0, 0, 0, 0);
        send_op(ipt_pkg::K_DELETE, 0, 0, 4'd3, 0);
        send_op(ipt_pkg::K_DELETE, 0, 0, 4'd15, 0);
        send_op(ipt_pkg::K_SHIFT, 0, 0, 0, 0);
        send_op(ipt_pkg::K_MISC, 0, 0, 0, 1);
        send_op(ipt_pkg::K_MISC, 0, 0, 0, 0);
        send_op(K_RESERVED, 4'hf, 16'hffff, 4'hf, 1);

        // sender holds off until every result is in
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            write_capacity(caps[ph]);
            for (int i = 0; i < 340; i++) begin
                no_gaps = (ph == 1 && i >= 100 && i < 200);
                random_op();
            end
        end
        no_gaps = 0;
        drain();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
